FILE: sv/jcs_pkg.sv
// Package for the joystick calibrate and scale block.
// Holds shared constants and the divider command and response structs.
package jcs_pkg;
   localparam int SampleCount = 32;
   localparam int ScaleLimit = 100;
   localparam int CntW = $clog2(SampleCount + 1);
   localparam int SumW = 10 + CntW;
   localparam int DivW = 32;

   localparam logic [9:0] WinLo = 10'd400;
   localparam logic [9:0] WinHi = 10'd600;

   localparam logic [2:0] RegShowLeds = 3'd0;
   localparam logic [2:0] RegDeadZone = 3'd1;
   localparam logic [2:0] RegPresetValid = 3'd2;
   localparam logic [2:0] RegPresetCx = 3'd3;
   localparam logic [2:0] RegPresetCy = 3'd4;
   localparam logic [2:0] RegPresetGx = 3'd5;
   localparam logic [2:0] RegPresetGy = 3'd6;

   localparam logic [1:0] LedOff = 2'd0;
   localparam logic [1:0] LedRed = 2'd1;
   localparam logic [1:0] LedBlue = 2'd2;

   typedef struct packed {
      logic start;
      logic [DivW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;
endpackage

FILE: sv/joystick_calibrate_and_scale_core.sv
// Top level of the joystick calibrate and scale block.
// Uses jcs_pkg and one shared jcs_divider for the calibration math.
//
// A normal request is accepted in the idle state and then passes through the x multiply
// state, the y multiply state that also applies the dead zone, and the state that packs
// the response. A calibration request goes to the calibration state; when it completes
// calibration, the two centers and two gains go one after another through the shared
// 32-step divider. The block takes one request at a time; the response is held in an
// output register, and the next request is accepted while it waits. A request stalls
// before its response only while that register is still full.
module joystick_calibrate_and_scale_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,  // raw_x, raw_y, button_raw, zero fill
   input  logic req_tuser,         // req_type
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,  // pos_x, pos_y, pressed, leds_update, led_west,
                                   // led_south, led_east, led_north
   output logic rsp_tuser,         // calibration_ready
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata
);
   import jcs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MULX, S_MULY, S_FIN, S_CAL, S_DIV_CX, S_DIV_CY, S_DIV_GX, S_DIV_GY,
      S_WAIT, S_OUT
   } state_type;

   state_type state_ff;
   logic show_leds_ff, preset_valid_ff;
   logic [3:0] dead_zone_ff;
   logic [9:0] pcx_ff, pcy_ff;
   logic [15:0] pgx_ff, pgy_ff;
   logic [9:0] lcx_ff, lcy_ff;
   logic [15:0] lgx_ff, lgy_ff;
   logic lvalid_ff, pblock_ff, calib_ff;
   logic [SumW-1:0] sumx_ff, sumy_ff;
   logic [CntW-1:0] ccnt_ff, scnt_ff;
   logic [9:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic [9:0] rx_ff, ry_ff;
   logic [7:0] btn_ff;
   logic [10:0] px_ff, py_ff;
   logic [26:0] prod;
   logic [9:0] mag_ff;
   logic neg_ff;
   logic [10:0] qx_ff;
   logic negx_ff;
   logic rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic rsp_user_ff;
   state_type next_div_ff;
   div_cmd_type dcmd;
   div_rsp_type drsp;
   logic btn_pressed;
   logic [1:0] led_w, led_s, led_e, led_n;
   logic in_center;
   logic [CntW-1:0] cc_next, sc_next;
   logic cal_done;
   logic rsp_free, rsp_load;

   wire [9:0] in_x = req_tdata[9:0];
   wire [9:0] in_y = req_tdata[19:10];
   wire [7:0] in_btn = req_tdata[27:20];

   jcs_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .rsp(drsp));

   wire active = lvalid_ff || (preset_valid_ff && !pblock_ff);
   wire [9:0] cx = lvalid_ff ? lcx_ff : pcx_ff;
   wire [9:0] cy = lvalid_ff ? lcy_ff : pcy_ff;
   wire [15:0] gx = lvalid_ff ? lgx_ff : pgx_ff;
   wire [15:0] gy = lvalid_ff ? lgy_ff : pgy_ff;

   function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
      absdiff = (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [10:0] clampq(input logic [26:0] p);
      logic [14:0] q;
      q = p[26:12];
      clampq = (q > 15'(ScaleLimit)) ? 11'(ScaleLimit) : q[10:0];
   endfunction

   logic [10:0] qcur;
   assign prod = mag_ff * ((state_ff == S_MULX) ? gx : gy);
   assign qcur = clampq(prod);

   wire [CntW-1:0] full = CntW'(SampleCount);
   wire [CntW-1:0] thr = CntW'(SampleCount - 1);

   function automatic logic [31:0] gain_num(input logic [9:0] lo, input logic [9:0] hi);
      logic [31:0] r;
      r = 32'(hi - lo);
      gain_num = (32'(200 * ScaleLimit) + r) << 12;
   endfunction

   always_comb begin
      dcmd = '0;
      case (state_ff)
         S_DIV_CX: begin
            dcmd.start = 1'b1; dcmd.dividend = 32'(sumx_ff); dcmd.divisor = 32'(ccnt_ff);
         end
         S_DIV_CY: begin
            dcmd.start = 1'b1; dcmd.dividend = 32'(sumy_ff); dcmd.divisor = 32'(ccnt_ff);
         end
         S_DIV_GX: begin
            dcmd.start = 1'b1; dcmd.dividend = gain_num(minx_ff, maxx_ff);
            dcmd.divisor = 32'(100) * 32'(maxx_ff - minx_ff);
         end
         S_DIV_GY: begin
            dcmd.start = 1'b1; dcmd.dividend = gain_num(miny_ff, maxy_ff);
            dcmd.divisor = 32'(100) * 32'(maxy_ff - miny_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      btn_pressed = (btn_ff == 8'd0);
      led_w = LedOff; led_s = LedOff; led_e = LedOff; led_n = LedOff;
      if (show_leds_ff) begin
         if (btn_pressed) begin
            led_w = LedRed; led_s = LedRed; led_e = LedRed; led_n = LedRed;
         end else begin
            if (rx_ff > WinHi) led_e = LedBlue; else if (rx_ff < WinLo) led_w = LedBlue;
            if (ry_ff > WinHi) led_n = LedBlue; else if (ry_ff < WinLo) led_s = LedBlue;
         end
      end
   end

   always_comb begin
      in_center = rx_ff > WinLo && rx_ff < WinHi && ry_ff > WinLo && ry_ff < WinHi;
      cc_next = ccnt_ff;
      sc_next = scnt_ff;
      if (in_center) begin
         if (ccnt_ff < full) cc_next = ccnt_ff + 1'b1;
      end else if (scnt_ff < full) begin
         sc_next = scnt_ff + 1'b1;
      end
      cal_done = cc_next >= thr && sc_next >= thr && cc_next != '0;
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = rsp_free && ((state_ff == S_FIN) || (state_ff == S_OUT) ||
                                  (state_ff == S_CAL && !cal_done));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   function automatic logic [15:0] sat16(input logic [31:0] q, input logic zero);
      sat16 = (zero || q > 32'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         next_div_ff <= S_IDLE;
         show_leds_ff <= 1'b0; dead_zone_ff <= 4'd3; preset_valid_ff <= 1'b0;
         pcx_ff <= 10'd512; pcy_ff <= 10'd512; pgx_ff <= 16'd4096; pgy_ff <= 16'd4096;
         lcx_ff <= '0; lcy_ff <= '0; lgx_ff <= '0; lgy_ff <= '0;
         lvalid_ff <= 1'b0; pblock_ff <= 1'b0; calib_ff <= 1'b0;
         sumx_ff <= '0; sumy_ff <= '0; ccnt_ff <= '0; scnt_ff <= '0;
         minx_ff <= 10'h3FF; miny_ff <= 10'h3FF; maxx_ff <= '0; maxy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               RegShowLeds: show_leds_ff <= csr_wdata[0];
               RegDeadZone: dead_zone_ff <= csr_wdata[3:0];
               RegPresetValid: preset_valid_ff <= csr_wdata[0];
               RegPresetCx: pcx_ff <= csr_wdata[9:0];
               RegPresetCy: pcy_ff <= csr_wdata[9:0];
               RegPresetGx: pgx_ff <= csr_wdata;
               RegPresetGy: pgy_ff <= csr_wdata;
               default: ;
            endcase
         end
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               rx_ff <= in_x; ry_ff <= in_y; btn_ff <= in_btn;
               if (!req_tuser) begin
                  calib_ff <= 1'b0;
                  mag_ff <= absdiff(in_x, cx);
                  neg_ff <= in_x < cx;
                  state_ff <= S_MULX;
               end else begin
                  if (!calib_ff) begin
                     sumx_ff <= '0; sumy_ff <= '0; ccnt_ff <= '0; scnt_ff <= '0;
                     minx_ff <= 10'h3FF; miny_ff <= 10'h3FF; maxx_ff <= '0; maxy_ff <= '0;
                     calib_ff <= 1'b1; lvalid_ff <= 1'b0; pblock_ff <= 1'b1;
                  end
                  state_ff <= S_CAL;
               end
            end
            S_MULX: begin
               qx_ff <= qcur; negx_ff <= neg_ff;
               mag_ff <= absdiff(ry_ff, cy); neg_ff <= ry_ff < cy;
               state_ff <= S_MULY;
            end
            S_MULY: begin
               if (qx_ff <= 11'(dead_zone_ff) && qcur <= 11'(dead_zone_ff)) begin
                  px_ff <= '0; py_ff <= '0;
               end else begin
                  px_ff <= negx_ff ? -qx_ff : qx_ff;
                  py_ff <= neg_ff ? -qcur : qcur;
               end
               state_ff <= S_FIN;
            end
            S_FIN: if (rsp_free) begin
               rsp_data_ff <= {led_n, led_e, led_s, led_w, show_leds_ff, btn_pressed,
                               active ? py_ff : {1'b0, ry_ff},
                               active ? px_ff : {1'b0, rx_ff}};
               rsp_user_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_CAL: if (cal_done || rsp_free) begin
               if (in_center) begin
                  if (ccnt_ff < full) begin
                     sumx_ff <= sumx_ff + SumW'(rx_ff); sumy_ff <= sumy_ff + SumW'(ry_ff);
                  end
               end else if (scnt_ff < full) begin
                  if (rx_ff > maxx_ff) maxx_ff <= rx_ff;
                  if (rx_ff < minx_ff) minx_ff <= rx_ff;
                  if (ry_ff > maxy_ff) maxy_ff <= ry_ff;
                  if (ry_ff < miny_ff) miny_ff <= ry_ff;
               end
               ccnt_ff <= cc_next; scnt_ff <= sc_next;
               if (cal_done) begin
                  state_ff <= S_DIV_CX;
               end else begin
                  rsp_data_ff <= '0;
                  rsp_user_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            S_DIV_CX: begin next_div_ff <= S_DIV_CY; state_ff <= S_WAIT; end
            S_DIV_CY: begin next_div_ff <= S_DIV_GX; state_ff <= S_WAIT; end
            S_DIV_GX: begin next_div_ff <= S_DIV_GY; state_ff <= S_WAIT; end
            S_DIV_GY: begin next_div_ff <= S_OUT; state_ff <= S_WAIT; end
            S_WAIT: if (drsp.done) begin
               case (next_div_ff)
                  S_DIV_CY: lcx_ff <= drsp.quotient[9:0];
                  S_DIV_GX: lcy_ff <= drsp.quotient[9:0];
                  S_DIV_GY: lgx_ff <= sat16(drsp.quotient, maxx_ff <= minx_ff);
                  default: lgy_ff <= sat16(drsp.quotient, maxy_ff <= miny_ff);
               endcase
               state_ff <= next_div_ff;
            end
            S_OUT: if (rsp_free) begin
               calib_ff <= 1'b0; lvalid_ff <= 1'b1;
               rsp_data_ff <= '0;
               rsp_user_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("request taken while busy");
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_data_ff) && $stable(rsp_user_ff))
      else $error("response changed while waiting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff) else $error("response dropped");
`endif
endmodule

FILE: sv/jcs_divider.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on jcs_pkg for the command and response structs.
module jcs_divider (
   input  logic clock,
   input  logic reset,
   input  jcs_pkg::div_cmd_type cmd,
   output jcs_pkg::div_rsp_type rsp
);
   import jcs_pkg::*;
   localparam int StepW = $clog2(DivW + 1);

   logic [DivW-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [StepW-1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DivW:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DivW-1]} - {1'b0, den_ff};
      if (cmd.start) begin
         rem_in = '0;
         quo_in = cmd.dividend;
         den_in = cmd.divisor;
         step_in = StepW'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DivW]) begin
            rem_in = trial[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DivW-2:0], quo_ff[DivW-1]};
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
